// File: rtl/gyro_bias_calibrate_and_scale_macros.svh
// Assertion helpers shared by the RTL. Each macro expects clk and rst_n in scope.
`ifndef GYRO_BIAS_CALIBRATE_AND_SCALE_MACROS_SVH
`define GYRO_BIAS_CALIBRATE_AND_SCALE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while in reset.
`define GBCS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gbcs assertion failed: same-cycle implication");

// Next-cycle implication, disabled while in reset.
`define GBCS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gbcs assertion failed: next-cycle implication");

`else

`define GBCS_ASSERT_IMP(lbl, ante, cons)
`define GBCS_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// File: rtl/gbcs_pkg.sv
package gbcs_pkg;

  // Field widths
  localparam int unsigned RAW_W   = 16;
  localparam int unsigned RAD_W   = 32;
  localparam int unsigned CNT_W   = 12;
  localparam int unsigned AXES    = 3;

  // Bias arithmetic
  localparam int unsigned SUM_W   = 28;
  localparam int unsigned BIAS_W  = 24;
  localparam int unsigned FRAC_W  = 8;
  localparam int unsigned NUM_W   = SUM_W + FRAC_W;   // dividend bits
  localparam int unsigned REM_W   = CNT_W;            // remainder stays below divisor

  // Rate arithmetic
  localparam int unsigned D_W     = BIAS_W + 1;       // raw*256 - bias
  localparam int unsigned GAIN_W  = 28;
  localparam int unsigned ACC_W   = GAIN_W + 2;
  localparam logic [GAIN_W-1:0] RATE_GAIN = 28'd146489361;  // 0.0174533/131 * 2^40
  localparam logic signed [ACC_W-1:0] GAIN_POS = ACC_W'(RATE_GAIN);
  localparam logic signed [ACC_W-1:0] GAIN_NEG = -GAIN_POS;

  // Sequencer step counter
  localparam int unsigned STEP_W  = 6;
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(NUM_W - 1);
  localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(D_W - 1);

  localparam logic [CNT_W-1:0] CALIB_RESET = 12'd256;

  typedef logic signed [RAW_W-1:0]  raw_t;
  typedef logic signed [RAD_W-1:0]  rad_t;
  typedef logic        [CNT_W-1:0]  cnt_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [BIAS_W-1:0] bias_t;

endpackage

// File: rtl/gbcs_if.sv
interface gbcs_in_if
  import gbcs_pkg::*;
();
  logic valid;
  logic ready;
  logic read_ok;
  raw_t accel_x_raw;
  raw_t accel_y_raw;
  raw_t accel_z_raw;
  raw_t rate_x_raw;
  raw_t rate_y_raw;
  raw_t rate_z_raw;

  modport source (
    output valid, read_ok, accel_x_raw, accel_y_raw, accel_z_raw,
           rate_x_raw, rate_y_raw, rate_z_raw,
    input  ready
  );
  modport sink (
    input  valid, read_ok, accel_x_raw, accel_y_raw, accel_z_raw,
           rate_x_raw, rate_y_raw, rate_z_raw,
    output ready
  );
endinterface

interface gbcs_out_if
  import gbcs_pkg::*;
();
  logic valid;
  logic ready;
  logic ok;
  raw_t accel_x_g;
  raw_t accel_y_g;
  raw_t accel_z_g;
  rad_t rate_x_rad;
  rad_t rate_y_rad;
  rad_t rate_z_rad;

  modport source (
    output valid, ok, accel_x_g, accel_y_g, accel_z_g,
           rate_x_rad, rate_y_rad, rate_z_rad,
    input  ready
  );
  modport sink (
    input  valid, ok, accel_x_g, accel_y_g, accel_z_g,
           rate_x_rad, rate_y_rad, rate_z_rad,
    output ready
  );
endinterface

interface gbcs_cfg_if
  import gbcs_pkg::*;
();
  logic valid;
  logic ready;
  cnt_t calib_samples;

  modport source (output valid, calib_samples, input ready);
  modport sink (input valid, calib_samples, output ready);
endinterface

// File: rtl/gyro_bias_calibrate_and_scale.sv
// Channel    Dir  Handshake       Payload
// cfg_chan   in   valid / ready   calib_samples (12 b), always ready
// in_chan    in   valid / ready   read_ok, accel_{x,y,z}_raw, rate_{x,y,z}_raw
// out_chan   out  valid / ready   ok, accel_{x,y,z}_g, rate_{x,y,z}_rad
//
// Calibration items are counted on acceptance and leave the sequencer idle. The item that
// closes calibration with a good read loads the dividend, runs 36 steps of the bit-serial
// restoring divider and rounds. Result items run the bit-serial shift-add multiplier 25
// steps over the bias-corrected rate, then round and load the output register.
// The output register lets the next item enter while a result waits; a finished result
// holds in the final step until the output register is free.
// Reset (rst_n low, synchronous) restores calib_samples to 256 and clears sums and bias.
`include "gyro_bias_calibrate_and_scale_macros.svh"

module gyro_bias_calibrate_and_scale
  import gbcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  gbcs_cfg_if.sink   cfg_chan,
  gbcs_in_if.sink    in_chan,
  gbcs_out_if.source out_chan
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DLOAD = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_DFIN  = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  // Control state
  logic [2:0]        state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  cnt_t              calib_r, calib_nxt;
  cnt_t              items_seen_r, items_seen_nxt;
  cnt_t              good_cnt_r, good_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Item and divider payload
  cnt_t              div_den_r, div_den_nxt;
  logic              ok_r, ok_nxt;
  raw_t              accel_r [AXES];
  raw_t              accel_nxt [AXES];
  raw_t              accel_out_r [AXES];
  raw_t              accel_out_nxt [AXES];
  logic              out_ok_r, out_ok_nxt;

  // Per-axis datapath
  sum_t              sum_r [AXES];
  sum_t              sum_nxt [AXES];
  bias_t             bias_r [AXES];
  bias_t             bias_nxt [AXES];
  logic              neg_r [AXES];
  logic              neg_nxt [AXES];
  logic [NUM_W-1:0]  nq_r [AXES];
  logic [NUM_W-1:0]  nq_nxt [AXES];
  logic [REM_W-1:0]  rem_r [AXES];
  logic [REM_W-1:0]  rem_nxt [AXES];
  logic [D_W-1:0]    d_r [AXES];
  logic [D_W-1:0]    d_nxt [AXES];
  logic signed [ACC_W-1:0] acc_r [AXES];
  logic signed [ACC_W-1:0] acc_nxt [AXES];
  logic [D_W-1:0]    low_r [AXES];
  logic [D_W-1:0]    low_nxt [AXES];
  rad_t              rad_r [AXES];
  rad_t              rad_nxt [AXES];

  raw_t              raw_rate [AXES];
  raw_t              raw_accel [AXES];

  logic              in_fire;
  logic              out_fire;
  logic              calib_phase;
  logic              cal_fire;
  logic              res_fire;
  logic              sum_en;
  cnt_t              good_after;
  cnt_t              items_after;
  logic              cal_last;
  logic              out_load;

  assign raw_rate[0]  = in_chan.rate_x_raw;
  assign raw_rate[1]  = in_chan.rate_y_raw;
  assign raw_rate[2]  = in_chan.rate_z_raw;
  assign raw_accel[0] = in_chan.accel_x_raw;
  assign raw_accel[1] = in_chan.accel_y_raw;
  assign raw_accel[2] = in_chan.accel_z_raw;

  // A new item enters only when the sequencer is free; the output register may still be full.
  assign in_chan.ready  = (state_r == ST_IDLE);
  assign cfg_chan.ready = 1'b1;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_fire = out_chan.valid && out_chan.ready;

  // calib_samples is 12 bits, so it never exceeds the 4095-sample ceiling.
  assign calib_phase = (items_seen_r < calib_r);
  assign cal_fire    = in_fire && calib_phase;
  assign res_fire    = in_fire && !calib_phase;
  assign sum_en      = cal_fire && in_chan.read_ok;
  assign good_after  = good_cnt_r + CNT_W'(sum_en);
  assign items_after = items_seen_r + CNT_W'(1);

  // Closing item with at least one good read: start the bias division.
  assign cal_last = cal_fire && (items_after == calib_r) && (good_after != '0);

  // Load the result once the output register is empty or being drained.
  assign out_load = (state_r == ST_FIN) && (!out_valid_r || out_chan.ready);

  // Sequencer and shared control
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    calib_nxt      = calib_r;
    items_seen_nxt = items_seen_r;
    good_cnt_nxt   = good_cnt_r;
    div_den_nxt    = div_den_r;
    ok_nxt         = ok_r;
    out_ok_nxt     = out_ok_r;
    out_valid_nxt  = out_valid_r && !out_fire;
    for (int i = 0; i < AXES; i++) begin
      accel_nxt[i]     = accel_r[i];
      accel_out_nxt[i] = accel_out_r[i];
    end

    if (cfg_chan.valid) begin
      calib_nxt = cfg_chan.calib_samples;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (cal_fire) begin
          // Count the item; a failed read is not summed.
          items_seen_nxt = items_after;
          good_cnt_nxt   = good_after;
          if (cal_last) begin
            div_den_nxt = good_after;
            state_nxt   = ST_DLOAD;
          end
        end else if (res_fire) begin
          ok_nxt = in_chan.read_ok;
          for (int i = 0; i < AXES; i++) begin
            accel_nxt[i] = raw_accel[i];
          end
          cnt_nxt   = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_DLOAD: begin
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + STEP_W'(1);
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_DFIN;
        end
      end
      ST_DFIN: begin
        state_nxt = ST_IDLE;
      end
      ST_MUL: begin
        cnt_nxt = cnt_r + STEP_W'(1);
        if (cnt_r == MUL_LAST) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // Hold here until the output register can take the result.
        if (out_load) begin
          out_ok_nxt    = ok_r;
          out_valid_nxt = 1'b1;
          for (int i = 0; i < AXES; i++) begin
            accel_out_nxt[i] = ok_r ? accel_r[i] : '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Per-axis lanes: running sum, bit-serial divider, bit-serial multiplier
  for (genvar g = 0; g < AXES; g++) begin : g_axis
    logic [SUM_W-1:0] mag;
    logic [REM_W:0]   trial;
    logic             ge;
    logic [BIAS_W-1:0] q;
    logic             rnd;
    logic signed [ACC_W-1:0] addend;
    logic signed [ACC_W-1:0] psum;
    logic signed [ACC_W:0]   hi;
    logic signed [ACC_W:0]   rsum;
    logic [BIAS_W-1:0] lowl;
    logic             pneg;
    logic             carry;

    always_comb begin
      sum_nxt[g]  = sum_r[g];
      bias_nxt[g] = bias_r[g];
      neg_nxt[g]  = neg_r[g];
      nq_nxt[g]   = nq_r[g];
      rem_nxt[g]  = rem_r[g];
      d_nxt[g]    = d_r[g];
      acc_nxt[g]  = acc_r[g];
      low_nxt[g]  = low_r[g];
      rad_nxt[g]  = rad_r[g];

      mag    = sum_r[g][SUM_W-1] ? (~sum_r[g] + SUM_W'(1)) : sum_r[g];
      trial  = {rem_r[g], nq_r[g][NUM_W-1]};
      ge     = (trial >= {1'b0, div_den_r});
      q      = nq_r[g][BIAS_W-1:0];
      rnd    = ({rem_r[g], 1'b0} >= {1'b0, div_den_r});

      // Top bit of d carries negative weight.
      if (d_r[g][0]) begin
        addend = (cnt_r == MUL_LAST) ? GAIN_NEG : GAIN_POS;
      end else begin
        addend = '0;
      end
      psum = acc_r[g] + addend;

      // Product is {acc, low}; round the >>24 result half away from zero.
      hi    = $signed({acc_r[g], low_r[g][D_W-1]});
      lowl  = low_r[g][BIAS_W-1:0];
      pneg  = acc_r[g][ACC_W-1];
      carry = pneg ? (lowl[BIAS_W-1] && (lowl[BIAS_W-2:0] != '0)) : lowl[BIAS_W-1];
      rsum  = hi + $signed({{ACC_W{1'b0}}, carry});

      if (sum_en) begin
        sum_nxt[g] = sum_r[g] + SUM_W'(raw_rate[g]);
      end

      if (res_fire) begin
        d_nxt[g]   = D_W'($signed({raw_rate[g], FRAC_W'(0)})) - D_W'(bias_r[g]);
        acc_nxt[g] = '0;
      end

      unique case (state_r)
        ST_DLOAD: begin
          neg_nxt[g] = sum_r[g][SUM_W-1];
          nq_nxt[g]  = {mag, FRAC_W'(0)};
          rem_nxt[g] = '0;
        end
        ST_DIV: begin
          // One quotient bit per cycle; the dividend shifts out as quotient shifts in.
          rem_nxt[g] = ge ? REM_W'(trial - {1'b0, div_den_r}) : trial[REM_W-1:0];
          nq_nxt[g]  = {nq_r[g][NUM_W-2:0], ge};
        end
        ST_DFIN: begin
          // Round on the remainder, then restore sign; only the low 24 bits are kept.
          bias_nxt[g] = neg_r[g] ? bias_t'(~q + BIAS_W'(!rnd)) : bias_t'(q + BIAS_W'(rnd));
        end
        ST_MUL: begin
          acc_nxt[g] = psum >>> 1;
          low_nxt[g] = {psum[0], low_r[g][D_W-1:1]};
          d_nxt[g]   = d_r[g] >> 1;
        end
        ST_FIN: begin
          // |product| < 2^52, so the rounded rate stays well inside 32 bits.
          if (out_load) begin
            rad_nxt[g] = ok_r ? RAD_W'(rsum) : '0;
          end
        end
        default: begin
        end
      endcase
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sum_r[g]  <= '0;
        bias_r[g] <= '0;
      end else begin
        sum_r[g]  <= sum_nxt[g];
        bias_r[g] <= bias_nxt[g];
      end
    end

    always_ff @(posedge clk) begin
      neg_r[g] <= neg_nxt[g];
      nq_r[g]  <= nq_nxt[g];
      rem_r[g] <= rem_nxt[g];
      d_r[g]   <= d_nxt[g];
      acc_r[g] <= acc_nxt[g];
      low_r[g] <= low_nxt[g];
      rad_r[g] <= rad_nxt[g];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      calib_r      <= CALIB_RESET;
      items_seen_r <= '0;
      good_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      calib_r      <= calib_nxt;
      items_seen_r <= items_seen_nxt;
      good_cnt_r   <= good_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_den_r <= div_den_nxt;
    ok_r      <= ok_nxt;
    out_ok_r  <= out_ok_nxt;
    for (int i = 0; i < AXES; i++) begin
      accel_r[i]     <= accel_nxt[i];
      accel_out_r[i] <= accel_out_nxt[i];
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.ok         = out_ok_r;
  assign out_chan.accel_x_g  = accel_out_r[0];
  assign out_chan.accel_y_g  = accel_out_r[1];
  assign out_chan.accel_z_g  = accel_out_r[2];
  assign out_chan.rate_x_rad = rad_r[0];
  assign out_chan.rate_y_rad = rad_r[1];
  assign out_chan.rate_z_rad = rad_r[2];

  `GBCS_ASSERT_IMP(a_good_within_seen, 1'b1, good_cnt_r <= items_seen_r)
  `GBCS_ASSERT_IMP(a_div_den_nonzero, (state_r == ST_DIV) || (state_r == ST_DFIN), div_den_r != '0)
  `GBCS_ASSERT_NXT(a_fin_waits, (state_r == ST_FIN) && out_valid_r && !out_chan.ready, (state_r == ST_FIN) && $stable(out_chan.rate_x_rad))
  `GBCS_ASSERT_IMP(a_fail_is_zero, out_chan.valid && !out_chan.ok, (out_chan.accel_x_g == '0) && (out_chan.rate_x_rad == '0) && (out_chan.rate_z_rad == '0))

endmodule
